// File: rtl/top_k_lowest_score_keeper_assert.svh
// Assertion macros used by the checker file.
`ifndef TOP_K_LOWEST_SCORE_KEEPER_ASSERT_SVH
`define TOP_K_LOWEST_SCORE_KEEPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TKLSK_AST_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tklsk check failed");

// Next-cycle implication, disabled while reset is low.
`define TKLSK_AST_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tklsk check failed");

`endif

// File: rtl/tklsk_pkg.sv
`default_nettype none
package tklsk_pkg;

  localparam int LIST_SIZE_DEF = 64;

  localparam int SCORE_W     = 32;
  localparam int TAG_W       = 32;
  localparam int FILL_W      = 7;
  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = SCORE_W + TAG_W;
  localparam int OUT_TDATA_W = 1 + SCORE_W + TAG_W + FILL_W;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_OFFER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic shift_en;
    logic load_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/tklsk_cell.sv
`default_nettype none
module tklsk_cell (
  input  wire                       clk,
  input  wire tklsk_pkg::cell_ctrl_t ctrl,
  input  wire tklsk_pkg::entry_t    load_ent,
  input  wire tklsk_pkg::entry_t    next_ent,
  output tklsk_pkg::entry_t         ent
);
  import tklsk_pkg::*;

  entry_t ent_r;

  // Load wins over shift; the sequencer never asks for both.
  always_ff @(posedge clk) begin
    if (ctrl.load_en) begin
      ent_r <= load_ent;
    end else if (ctrl.shift_en) begin
      ent_r <= next_ent;
    end
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

// File: rtl/top_k_lowest_score_keeper.sv
`default_nettype none
// Keeps the LIST_SIZE candidates (score, tag) with the lowest scores. Offers
// (tuser 0) append while the list is not full; the append that fills it
// moves the worst entry (highest score, first one on ties) to the front,
// others keeping order. Once full, an offer scoring strictly below the front
// replaces it and the new worst is moved to the front again. Each offer
// returns one status transfer with the accepted flag and the current worst.
// A read (tuser 1) streams the held entries front first, tlast on the final
// one, or a single empty-list transfer when nothing is held. Storage is a
// ring of cells that rotates one place per cycle toward the front, pausing
// while a read waits on an output stall. An append or a rejected offer goes
// straight to its status, the append that fills the list makes one rotation
// to move the worst, a replacing offer two (one to find the worst, one to
// move it), and a read one rotation plus any output stall. One item is
// worked on at a time; the next is taken while the last result still waits
// at the output register. Scores compare as plain unsigned integers.
module top_k_lowest_score_keeper #(
  parameter int LIST_SIZE = tklsk_pkg::LIST_SIZE_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  // [31:0] cand_score, [63:32] cand_tag
  input  wire  [tklsk_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [0] operation
  input  wire                                    in_tuser,
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  // [0] accepted, [32:1] out_score, [64:33] out_tag, [71:65] fill_count
  output logic [tklsk_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // [1:0] result_kind
  output logic [tklsk_pkg::KIND_W-1:0]           out_tuser,
  output logic                                   out_tlast
);
  import tklsk_pkg::*;

  localparam int CW = $clog2(LIST_SIZE + 1);
  localparam int IW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(LIST_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(LIST_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_MOVE, ST_READ, ST_STATUS
  } state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      t_r, t_nxt;            // rotation step
  logic [CW-1:0]      count_r, count_nxt;
  entry_t             worst_r, worst_nxt;    // worst held entry, first max
  logic [IW-1:0]      worst_idx_r, worst_idx_nxt;
  entry_t             cand_r, cand_nxt;
  entry_t             prev_r, prev_nxt;      // registered copy of the head
  logic               acc_r, acc_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic               out_acc_r, out_acc_nxt;
  entry_t             out_ent_r, out_ent_nxt;
  logic [FILL_W-1:0]  out_fill_r, out_fill_nxt;
  logic               out_last_r, out_last_nxt;

  entry_t             in_ent;
  entry_t             head;
  entry_t             feed;
  entry_t             search_val;
  logic               shift_en;
  logic               load_req;
  logic               can_emit;
  logic               out_load;
  logic [CW+FILL_W-1:0] cnt_ext;
  logic [FILL_W-1:0]  fill_now;

  entry_t             cell_ent [LIST_SIZE];

  assign in_ent.score = in_tdata[SCORE_W-1:0];
  assign in_ent.tag   = in_tdata[SCORE_W +: TAG_W];
  assign head         = cell_ent[0];
  assign in_tready    = (state_r == ST_IDLE);
  assign can_emit     = !out_valid_r || out_tready;
  assign cnt_ext      = {{FILL_W{1'b0}}, count_r};
  assign fill_now     = cnt_ext[FILL_W-1:0];

  // Ring of cells: each shifts toward the front, the last takes the feed.
  for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     next_ent;
    assign ctrl.shift_en = shift_en;
    assign ctrl.load_en  = load_req && (count_r == CW'(i));
    if (i == LIST_SIZE - 1) begin : g_tail
      assign next_ent = feed;
    end else begin : g_mid
      assign next_ent = cell_ent[i+1];
    end
    tklsk_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_ent (in_ent),
      .next_ent (next_ent),
      .ent      (cell_ent[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    count_nxt     = count_r;
    worst_nxt     = worst_r;
    worst_idx_nxt = worst_idx_r;
    cand_nxt      = cand_r;
    prev_nxt      = head;
    acc_nxt       = acc_r;
    kind_nxt      = kind_r;
    shift_en      = 1'b0;
    load_req      = 1'b0;
    feed          = head;
    search_val    = (t_r == '0) ? cand_r : head;
    out_load      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_acc_nxt   = out_acc_r;
    out_ent_nxt   = out_ent_r;
    out_fill_nxt  = out_fill_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          t_nxt = '0;
          if (in_tuser == OP_OFFER) begin
            kind_nxt = KIND_OFFER;
            if (count_r != FULL_CNT) begin
              // append at the fill position, track the first maximum
              load_req  = 1'b1;
              count_nxt = count_r + CW'(1);
              acc_nxt   = 1'b1;
              if (count_r == '0 || in_ent.score > worst_r.score) begin
                worst_nxt     = in_ent;
                worst_idx_nxt = count_r[IW-1:0];
              end
              state_nxt = (count_r == FULL_CNT - CW'(1)) ? ST_MOVE : ST_STATUS;
            end else if (in_ent.score < worst_r.score) begin
              // front holds the worst; replace it during the search pass
              cand_nxt  = in_ent;
              acc_nxt   = 1'b1;
              state_nxt = ST_SEARCH;
            end else begin
              acc_nxt   = 1'b0;
              state_nxt = ST_STATUS;
            end
          end else begin
            if (count_r == '0) begin
              kind_nxt  = KIND_EMPTY;
              state_nxt = ST_STATUS;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end

      ST_SEARCH: begin
        // full rotation: swap the candidate in at the front, find first max
        shift_en = 1'b1;
        feed     = search_val;
        if (t_r == '0 || search_val.score > worst_r.score) begin
          worst_nxt     = search_val;
          worst_idx_nxt = t_r;
        end
        if (t_r == LAST_IDX) begin
          t_nxt     = '0;
          state_nxt = ST_MOVE;
        end else begin
          t_nxt = t_r + IW'(1);
        end
      end

      ST_MOVE: begin
        // full rotation: feed worst first, then the rest in order minus worst
        shift_en = 1'b1;
        if (t_r == '0) begin
          feed = worst_r;
        end else if (t_r <= worst_idx_r) begin
          feed = prev_r;
        end else begin
          feed = head;
        end
        if (t_r == LAST_IDX) begin
          t_nxt     = '0;
          state_nxt = ST_STATUS;
        end else begin
          t_nxt = t_r + IW'(1);
        end
      end

      ST_READ: begin
        // emit held entries from the head, rotate unused cells silently
        if (CW'(t_r) < count_r) begin
          if (can_emit) begin
            out_load     = 1'b1;
            out_kind_nxt = KIND_ENTRY;
            out_acc_nxt  = 1'b0;
            out_ent_nxt  = head;
            out_fill_nxt = fill_now;
            out_last_nxt = (CW'(t_r) + CW'(1) == count_r);
            shift_en     = 1'b1;
          end
        end else begin
          shift_en = 1'b1;
        end
        if (shift_en) begin
          if (t_r == LAST_IDX) begin
            t_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            t_nxt = t_r + IW'(1);
          end
        end
      end

      ST_STATUS: begin
        if (can_emit) begin
          out_load     = 1'b1;
          out_kind_nxt = kind_r;
          out_last_nxt = 1'b1;
          if (kind_r == KIND_EMPTY) begin
            out_acc_nxt  = 1'b0;
            out_ent_nxt  = '0;
            out_fill_nxt = '0;
          end else begin
            out_acc_nxt  = acc_r;
            out_ent_nxt  = worst_r;
            out_fill_nxt = fill_now;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t_r         <= t_nxt;
    worst_r     <= worst_nxt;
    worst_idx_r <= worst_idx_nxt;
    cand_r      <= cand_nxt;
    prev_r      <= prev_nxt;
    acc_r       <= acc_nxt;
    kind_r      <= kind_nxt;
    out_kind_r  <= out_kind_nxt;
    out_acc_r   <= out_acc_nxt;
    out_ent_r   <= out_ent_nxt;
    out_fill_r  <= out_fill_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_fill_r, out_ent_r.tag, out_ent_r.score, out_acc_r};

endmodule
`default_nettype wire

// File: rtl/tklsk_checker.sv
`default_nettype none
`include "top_k_lowest_score_keeper_assert.svh"
module tklsk_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [tklsk_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire [tklsk_pkg::KIND_W-1:0]        out_tuser,
  input wire                                out_tlast
);
  import tklsk_pkg::*;

  // Empty-list marker is a lone, all-zero transfer.
  `TKLSK_AST_IMPL(a_empty_zero, clk, rst_n, out_tvalid && out_tuser == KIND_EMPTY, out_tlast && out_tdata == '0)

  // Offer status always closes its item.
  `TKLSK_AST_IMPL(a_status_last, clk, rst_n, out_tvalid && out_tuser == KIND_OFFER, out_tlast)

  // List entries never carry the accepted flag.
  `TKLSK_AST_IMPL(a_entry_noacc, clk, rst_n, out_tvalid && out_tuser == KIND_ENTRY, !out_tdata[0])

  // A stalled result holds.
  `TKLSK_AST_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind top_k_lowest_score_keeper tklsk_checker u_tklsk_checker (.*);
`default_nettype wire
